@@ design/sbt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the scan block tracker.
package sbt_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int QueueDepth = 2;

  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_CHECK   = 2'd0,
    KIND_ATTEMPT = 2'd1,
    KIND_BLOCK   = 2'd2,
    KIND_UNBLOCK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_WINDOW = 3'd0,
    REG_THRESH = 3'd1,
    REG_FIRST  = 3'd2,
    REG_SECOND = 3'd3,
    REG_LATER  = 3'd4
  } reg_idx_t;

  // Item as queued between front and back.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] now;
    logic [31:0] mdur;
  } item_t;

  // One table row: address, attempts, window start, strikes, blocked, block end.
  localparam int RowW = 32 + 16 + 32 + 8 + 1 + 32;
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] attempts;
    logic [31:0] win_start;
    logic [7:0]  strikes;
    logic        blocked;
    logic [31:0] block_end;
  } row_t;

  function automatic logic [31:0] sat_end(input logic [31:0] now, input logic [31:0] dur);
    logic [32:0] s;
    s = {1'b0, now} + {1'b0, dur};
    return s[32] ? AllOnes : s[31:0];
  endfunction

endpackage

@@ design/sbt_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module sbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/sbt_front.sv @@
`timescale 1ns / 1ps
// Front end: input beat acceptance and a short item queue.
module sbt_front import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] source_address,
  input  logic [31:0] now_seconds,
  input  logic [31:0] manual_duration,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);
  item_t slots [QueueDepth];
  logic  rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'(QueueDepth));
  assign push = in_valid && in_ready;
  assign pop = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind_t'(kind), addr: source_address,
                         now: now_seconds, mdur: manual_duration};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ design/sbt_back.sv @@
`timescale 1ns / 1ps
// Back end: sequential table search, entry update and result register.
module sbt_back import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  input  logic [31:0] window_seconds,
  input  logic [15:0] attempt_threshold,
  input  logic [31:0] first_block_seconds,
  input  logic [31:0] second_block_seconds,
  input  logic [31:0] later_block_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_blocked,
  output logic        block_set,
  output logic [7:0]  strike_count,
  output logic [31:0] blocks_total
);
  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_WAIT, ST_EVAL, ST_OUT} state_t;

  state_t          state;
  item_t           cur;
  logic [TableEntries-1:0] valid_bits;
  logic [CntW-1:0] scan;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic            hit, free_found;
  logic [CntW-1:0] rd_cnt;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  row_t            ram_wdata, ram_rdata;

  // Read pipeline: address issued one cycle, data checked the next.
  logic            chk_v;
  logic [IdxW-1:0] chk_idx;

  sbt_ram #(.Width(RowW), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Evaluation of the matched/new entry.
  row_t        r, r_new;
  logic        e_blk, e_set, e_write, e_valid;
  logic [7:0]  e_str;
  logic [16:0] inc_att;
  logic [7:0]  ns;
  logic [31:0] dur;
  logic        have;

  always_comb begin
    r = ram_rdata;
    r_new = r;
    e_blk = 1'b0;
    e_set = 1'b0;
    e_write = 1'b0;
    e_valid = 1'b0;
    have = hit;
    inc_att = '0;
    ns = '0;
    dur = '0;
    case (cur.kind)
      KIND_CHECK: begin
        if (hit && r.blocked) begin
          if (r.block_end == AllOnes || r.block_end > cur.now) begin
            e_blk = 1'b1;
          end else begin
            r_new.blocked = 1'b0;
            r_new.attempts = '0;
            e_write = 1'b1;
          end
        end
      end
      KIND_ATTEMPT: begin
        if (!hit) begin
          if (free_found) begin
            r_new = '{addr: cur.addr, attempts: 16'd1, win_start: cur.now,
                      strikes: 8'd0, blocked: 1'b0, block_end: 32'd0};
            e_write = 1'b1;
            e_valid = 1'b1;
            have = 1'b1;
          end
        end else if ((cur.now - r.win_start) > window_seconds) begin
          r_new.attempts = 16'd1;
          r_new.win_start = cur.now;
          e_write = 1'b1;
        end else begin
          inc_att = (r.attempts != 16'hFFFF) ? {1'b0, r.attempts} + 17'd1
                                             : {1'b0, r.attempts};
          r_new.attempts = inc_att[15:0];
          e_write = 1'b1;
          if (inc_att[15:0] > attempt_threshold) begin
            ns = (r.strikes != 8'hFF) ? r.strikes + 8'd1 : r.strikes;
            if (ns == 8'd1) dur = first_block_seconds;
            else if (ns == 8'd2) dur = second_block_seconds;
            else dur = later_block_seconds;
            r_new.strikes = ns;
            r_new.block_end = sat_end(cur.now, dur);
            r_new.blocked = 1'b1;
            r_new.attempts = '0;
            e_blk = 1'b1;
            e_set = 1'b1;
          end
        end
      end
      KIND_BLOCK: begin
        if (!hit && free_found) begin
          r_new = '{addr: cur.addr, attempts: 16'd0, win_start: cur.now,
                    strikes: 8'd0, blocked: 1'b0, block_end: 32'd0};
          e_valid = 1'b1;
          have = 1'b1;
        end
        if (have) begin
          r_new.blocked = 1'b1;
          r_new.block_end = (cur.mdur != 32'd0) ? sat_end(cur.now, cur.mdur) : AllOnes;
          e_set = 1'b1;
          e_write = 1'b1;
        end
      end
      default: begin
        if (hit) begin
          r_new.blocked = 1'b0;
          r_new.block_end = '0;
          r_new.strikes = '0;
          r_new.attempts = '0;
          e_write = 1'b1;
        end
      end
    endcase
    e_str = have ? r_new.strikes : 8'd0;
  end

  logic [IdxW-1:0] tgt;
  assign tgt = hit ? hit_idx : free_idx;

  always_comb begin
    ram_we = 1'b0;
    ram_addr = scan[IdxW-1:0];
    ram_wdata = r_new;
    if (state == ST_EVAL) begin
      ram_addr = tgt;
      ram_we = e_write;
    end else if (state == ST_WAIT) begin
      ram_addr = tgt;
    end
  end

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign rd_cnt = CntW'(TableEntries);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid_bits <= '0;
      out_valid <= 1'b0;
      blocks_total <= '0;
      chk_v <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            scan <= '0;
            hit <= 1'b0;
            free_found <= 1'b0;
            chk_v <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle; compare the data of the previous read.
          chk_v <= (scan != rd_cnt) && !hit;
          chk_idx <= scan[IdxW-1:0];
          if (scan != rd_cnt) scan <= scan + CntW'(1);
          if (chk_v && !hit) begin
            if (!valid_bits[chk_idx]) begin
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx <= chk_idx;
              end
            end else if (ram_rdata.addr == cur.addr) begin
              hit <= 1'b1;
              hit_idx <= chk_idx;
            end
          end
          if (hit || (scan == rd_cnt && !chk_v)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (e_valid) valid_bits[free_idx] <= 1'b1;
          if (e_set) blocks_total <= blocks_total + 32'd1;
          is_blocked <= e_blk;
          block_set <= e_set;
          strike_count <= e_str;
          out_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/scan_block_tracker_core.sv @@
`timescale 1ns / 1ps
// Top level of the scan block tracker.
// Each item takes one table search of up to 64 single-port RAM reads, one
// per cycle, then a read-modify-write of the chosen entry; the back end
// finishes one item before it takes the next from the queue. A two-entry
// queue takes new beats while the back end works. Configuration registers
// are written by cfg_we with cfg_index 0..4; other indexes are ignored.
module scan_block_tracker_core import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] source_address,
  input  logic [31:0] now_seconds,
  input  logic [31:0] manual_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_blocked,
  output logic        block_set,
  output logic [7:0]  strike_count,
  output logic [31:0] blocks_total
);
  logic [31:0] window_seconds, first_block_seconds, second_block_seconds;
  logic [31:0] later_block_seconds;
  logic [15:0] attempt_threshold;
  logic        q_valid, q_pop;
  item_t       q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= 32'd60;
      attempt_threshold <= 16'd10;
      first_block_seconds <= 32'd60;
      second_block_seconds <= 32'd600;
      later_block_seconds <= 32'd86400;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW: window_seconds <= cfg_data;
        REG_THRESH: attempt_threshold <= cfg_data[15:0];
        REG_FIRST:  first_block_seconds <= cfg_data;
        REG_SECOND: second_block_seconds <= cfg_data;
        REG_LATER:  later_block_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  sbt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .source_address, .now_seconds,
    .manual_duration, .q_valid, .q_pop, .q_item
  );

  sbt_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_item, .window_seconds, .attempt_threshold,
    .first_block_seconds, .second_block_seconds, .later_block_seconds,
    .out_valid, .out_ready, .is_blocked, .block_set, .strike_count, .blocks_total
  );
endmodule
